// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define SITDA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("sitda check failed");

// Next-cycle implication, off while reset is asserted.
`define SITDA_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("sitda check failed");

// Next-cycle implication, checked through reset as well.
`define SITDA_ASSERT_NXT_ALL(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("sitda check failed");

`endif

// ===== src/sitda_pkg.sv =====
// Shared types, character codes and the BCD digit correction.
`timescale 1ns / 1ps
package sitda_pkg;

    typedef logic [7:0] char_t;
    typedef logic [3:0] digit_t;

    localparam int DIGIT_BITS = 4;
    localparam int BITS_PER_STAGE = 4;

    localparam char_t CHAR_ZERO = 8'd48;
    localparam char_t CHAR_MINUS = 8'd45;

    function automatic digit_t add3(input digit_t d);
        return (d >= 4'd5) ? digit_t'(d + 4'd3) : d;
    endfunction

endpackage

// ===== src/sitda_dabble_stage.sv =====
// One pipeline stage of the shift-and-add-3 binary to BCD conversion.
`timescale 1ns / 1ps
module sitda_dabble_stage
    import sitda_pkg::*;
#(
    parameter int NUM_DIGITS = 10,
    parameter int PAD_BITS = 32
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             in_neg,
    input  logic [NUM_DIGITS*DIGIT_BITS-1:0] in_bcd,
    input  logic [PAD_BITS-1:0]              in_rem,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             out_neg,
    output logic [NUM_DIGITS*DIGIT_BITS-1:0] out_bcd,
    output logic [PAD_BITS-1:0]              out_rem
);

    localparam int BCD_BITS = NUM_DIGITS * DIGIT_BITS;

    logic                valid_reg;
    logic                neg_reg;
    logic [BCD_BITS-1:0] bcd_reg;
    logic [BCD_BITS-1:0] bcd_next;
    logic [PAD_BITS-1:0] rem_reg;
    logic [PAD_BITS-1:0] rem_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_neg   = neg_reg;
    assign out_bcd   = bcd_reg;
    assign out_rem   = rem_reg;

    always_comb begin
        bcd_next = in_bcd;
        rem_next = in_rem;
        for (int s = 0; s < BITS_PER_STAGE; s++) begin
            for (int d = 0; d < NUM_DIGITS; d++) begin
                bcd_next[d*DIGIT_BITS +: DIGIT_BITS] = add3(bcd_next[d*DIGIT_BITS +: DIGIT_BITS]);
            end
            bcd_next = {bcd_next[BCD_BITS-2:0], rem_next[PAD_BITS-1]};
            rem_next = {rem_next[PAD_BITS-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_valid && in_ready) begin
            neg_reg <= in_neg;
            bcd_reg <= bcd_next;
            rem_reg <= rem_next;
        end
    end

endmodule

// ===== src/sitda_serializer.sv =====
// Character serializer: sign, then significant digits, one beat per cycle while m_ready is high.
`timescale 1ns / 1ps
module sitda_serializer
    import sitda_pkg::*;
#(
    parameter int NUM_DIGITS = 10
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             in_neg,
    input  logic [NUM_DIGITS*DIGIT_BITS-1:0] in_bcd,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [7:0]                       m_character,
    output logic                             m_last
);

    localparam int BCD_BITS = NUM_DIGITS * DIGIT_BITS;
    localparam int IDX_BITS = $clog2(NUM_DIGITS);

    function automatic logic [IDX_BITS-1:0] msd_index(input logic [BCD_BITS-1:0] bcd);
        logic [IDX_BITS-1:0] idx;
        idx = '0;
        for (int k = 0; k < NUM_DIGITS; k++) begin
            if (bcd[k*DIGIT_BITS +: DIGIT_BITS] != '0) begin
                idx = IDX_BITS'(k);
            end
        end
        return idx;
    endfunction

    logic                busy_reg;
    logic                sign_reg;
    logic [IDX_BITS-1:0] idx_reg;
    logic [BCD_BITS-1:0] bcd_reg;
    digit_t              digit;
    logic                load;

    assign digit       = bcd_reg[idx_reg*DIGIT_BITS +: DIGIT_BITS];
    assign m_valid     = busy_reg;
    assign m_last      = busy_reg && !sign_reg && (idx_reg == '0);
    assign m_character = sign_reg ? CHAR_MINUS : char_t'(CHAR_ZERO + char_t'(digit));
    assign in_ready    = !busy_reg || (m_ready && m_last);
    assign load        = in_valid && in_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            sign_reg <= 1'b0;
            idx_reg  <= '0;
        end else if (load) begin
            busy_reg <= 1'b1;
            sign_reg <= in_neg;
            idx_reg  <= msd_index(in_bcd);
        end else if (busy_reg && m_ready) begin
            if (sign_reg) begin
                sign_reg <= 1'b0;
            end else if (idx_reg == '0) begin
                busy_reg <= 1'b0;
            end else begin
                idx_reg <= idx_reg - 1'b1;
            end
        end
        if (load) begin
            bcd_reg <= in_bcd;
        end
    end

endmodule

// ===== src/signed_int_to_decimal_ascii.sv =====
// Signed integer to decimal ASCII converter, top level.
// Each value beat on s_ becomes its decimal text on m_: a '-' for negative values, then the
// digits of the magnitude with no leading zeros (zero gives a single '0'); m_last marks the
// final character. A value passes a sign/magnitude register, one shift-and-add-3 stage per
// four magnitude bits (eight stages at 32 bits), then the character serializer's register
// before its first character appears. The serializer sends one character per cycle while
// m_ready is high and takes the next value on the cycle its last character is taken, so a
// value holds the output for one character each for its sign, if negative, and its digits;
// the stages in front keep accepting values until they fill.
`timescale 1ns / 1ps
module signed_int_to_decimal_ascii
    import sitda_pkg::*;
#(
    parameter int VALUE_BITS = 32
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [VALUE_BITS-1:0] s_value,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [7:0]                   m_character,
    output logic                         m_last
);

    localparam int NUM_DIGITS = ((VALUE_BITS - 1) * 30103) / 100000 + 1;
    localparam int NUM_STAGES = (VALUE_BITS + BITS_PER_STAGE - 1) / BITS_PER_STAGE;
    localparam int PAD_BITS   = NUM_STAGES * BITS_PER_STAGE;
    localparam int BCD_BITS   = NUM_DIGITS * DIGIT_BITS;

    logic                  front_valid_reg;
    logic                  front_neg_reg;
    logic [VALUE_BITS-1:0] front_mag_reg;
    logic [VALUE_BITS-1:0] raw;
    logic [VALUE_BITS-1:0] mag_next;

    logic [NUM_STAGES:0]   st_valid;
    logic [NUM_STAGES:0]   st_ready;
    logic [NUM_STAGES:0]   st_neg;
    logic [BCD_BITS-1:0]   st_bcd [NUM_STAGES+1];
    logic [PAD_BITS-1:0]   st_rem [NUM_STAGES+1];

    assign raw      = s_value;
    assign mag_next = raw[VALUE_BITS-1] ? (~raw + 1'b1) : raw;
    assign s_ready  = !front_valid_reg || st_ready[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_valid_reg <= 1'b0;
        end else if (s_ready) begin
            front_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            front_neg_reg <= raw[VALUE_BITS-1];
            front_mag_reg <= mag_next;
        end
    end

    assign st_valid[0] = front_valid_reg;
    assign st_neg[0]   = front_neg_reg;
    assign st_bcd[0]   = '0;
    assign st_rem[0]   = PAD_BITS'(front_mag_reg);

    for (genvar i = 0; i < NUM_STAGES; i++) begin : g_stage
        sitda_dabble_stage #(
            .NUM_DIGITS (NUM_DIGITS),
            .PAD_BITS   (PAD_BITS)
        ) u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (st_valid[i]),
            .in_ready  (st_ready[i]),
            .in_neg    (st_neg[i]),
            .in_bcd    (st_bcd[i]),
            .in_rem    (st_rem[i]),
            .out_valid (st_valid[i+1]),
            .out_ready (st_ready[i+1]),
            .out_neg   (st_neg[i+1]),
            .out_bcd   (st_bcd[i+1]),
            .out_rem   (st_rem[i+1])
        );
    end

    sitda_serializer #(
        .NUM_DIGITS (NUM_DIGITS)
    ) u_serializer (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (st_valid[NUM_STAGES]),
        .in_ready    (st_ready[NUM_STAGES]),
        .in_neg      (st_neg[NUM_STAGES]),
        .in_bcd      (st_bcd[NUM_STAGES]),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_character (m_character),
        .m_last      (m_last)
    );

endmodule

// ===== src/sitda_checker.sv =====
// Port-level checker for the converter and its bind to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sitda_checker
    import sitda_pkg::*;
#(
    parameter int VALUE_BITS = 32
) (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_valid,
    input logic                         s_ready,
    input logic signed [VALUE_BITS-1:0] s_value,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic [7:0]                   m_character,
    input logic                         m_last
);

    logic       char_ok;
    logic [8:0] out_beat;

    assign char_ok  = (m_character == CHAR_MINUS)
                   || ((m_character >= CHAR_ZERO) && (m_character <= 8'd57));
    assign out_beat = {m_character, m_last};

    `SITDA_ASSERT_NXT(a_in_hold, aclk, aresetn, s_valid && !s_ready, s_valid && $stable(s_value))
    `SITDA_ASSERT_NXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(out_beat))
    `SITDA_ASSERT_IMP(a_char_set, aclk, aresetn, m_valid, char_ok)
    `SITDA_ASSERT_IMP(a_minus_not_last, aclk, aresetn, m_valid && (m_character == CHAR_MINUS), !m_last)
    `SITDA_ASSERT_NXT_ALL(a_reset_idle, aclk, !aresetn, !m_valid)

endmodule

bind signed_int_to_decimal_ascii sitda_checker #(.VALUE_BITS(VALUE_BITS)) u_sitda_checker (.*);
